FILE: rtl/abkf_pkg.sv
// Shared constants, widths and helpers for the angle/bias Kalman filter.
// No dependencies. Imported by the filter top level, its arithmetic units and the testbench.
`default_nettype none

package abkf_pkg;

  // CORDIC iteration count, valid range 8..30
  localparam int CORDIC_STEPS = 16;
  localparam int CIW          = $clog2(CORDIC_STEPS);

  // CORDIC datapath widths: x/y hold accel << 14 plus gain growth
  localparam int XYW = 34;
  localparam int ZW  = 20;
  localparam logic signed [ZW-1:0] PI_Q16 = 20'sd205887;

  // serial multiplier: 33 x 33 signed, radix 2
  localparam int MUL_OW    = 33;
  localparam int MUL_STEPS = 33;
  localparam int MUL_CW    = $clog2(MUL_STEPS);
  localparam int PW        = 2 * MUL_OW + 1;

  // restoring divider: |num| (33 bits) << 28 over a 33-bit divisor
  localparam int DIV_NW = 33;
  localparam int DIV_QW = DIV_NW + 28;
  localparam int DIV_CW = $clog2(DIV_QW);

  // configuration register indexes
  localparam logic [31:0] CFG_TIME_STEP     = 32'd0;
  localparam logic [31:0] CFG_MEASURE_NOISE = 32'd1;
  localparam logic [31:0] CFG_ANGLE_NOISE   = 32'd2;
  localparam logic [31:0] CFG_BIAS_NOISE    = 32'd3;

  localparam logic signed [31:0] ONE_Q28 = 32'sh1000_0000;

  // atan(2^-i) in Q16.16
  function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
    logic [15:0] v;
    begin
      case (i)
        5'd0:  v = 16'd51472;
        5'd1:  v = 16'd30386;
        5'd2:  v = 16'd16055;
        5'd3:  v = 16'd8150;
        5'd4:  v = 16'd4091;
        5'd5:  v = 16'd2047;
        5'd6:  v = 16'd1024;
        5'd7:  v = 16'd512;
        5'd8:  v = 16'd256;
        5'd9:  v = 16'd128;
        5'd10: v = 16'd64;
        5'd11: v = 16'd32;
        5'd12: v = 16'd16;
        5'd13: v = 16'd8;
        5'd14: v = 16'd4;
        5'd15: v = 16'd2;
        5'd16: v = 16'd1;
        default: v = 16'd0;
      endcase
      return $signed({{(ZW-16){1'b0}}, v});
    end
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    begin
      if (v > 40'sh00_7FFF_FFFF)
        return 32'sh7FFF_FFFF;
      else if (v < -40'sh00_8000_0000)
        return 32'sh8000_0000;
      else
        return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/abkf_mul.sv
// Bit-serial signed multiplier, 33 x 33 -> 67 bits, one multiplier bit per cycle.
// Depends on abkf_pkg.
`default_nettype none

module abkf_mul
  import abkf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [MUL_OW-1:0] a,
  input  wire logic signed [MUL_OW-1:0] b,
  output logic                          done,
  output logic signed [PW-1:0]          prod
);

  logic signed [MUL_OW:0]   hi_r;
  logic [MUL_OW-1:0]        lo_r;
  logic signed [MUL_OW-1:0] a_r;
  logic [MUL_CW-1:0]        cnt_r;
  logic                     run_r;
  logic                     done_r;
  logic                     last;
  logic signed [MUL_OW:0]   sum;

  assign last = (cnt_r == MUL_CW'(MUL_STEPS - 1));

  // top multiplier bit carries negative weight
  always_comb begin
    if (!lo_r[0])
      sum = hi_r;
    else if (last)
      sum = hi_r - (MUL_OW+1)'(a_r);
    else
      sum = hi_r + (MUL_OW+1)'(a_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        hi_r  <= '0;
        lo_r  <= b;
        a_r   <= a;
      end else if (run_r) begin
        hi_r  <= {sum[MUL_OW], sum[MUL_OW:1]};
        lo_r  <= {sum[0], lo_r[MUL_OW-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

`default_nettype wire

FILE: rtl/abkf_div.sv
// Restoring divider for the Kalman gain: sat32((num << 28) / den), den > 0,
// truncating toward zero, one quotient bit per cycle. Depends on abkf_pkg.
`default_nettype none

module abkf_div
  import abkf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic [32:0]        den,
  output logic                    done,
  output logic signed [31:0]      quo
);

  logic [DIV_QW-1:0] q_r;
  logic [32:0]       rem_r;
  logic [32:0]       den_r;
  logic              neg_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              run_r;
  logic              done_r;
  logic [DIV_NW-1:0] mag;
  logic [33:0]       shifted;
  logic [34:0]       trial;
  logic              ovf;

  assign mag     = num[31] ? DIV_NW'(-{num[31], num}) : DIV_NW'({1'b0, num});
  assign shifted = {rem_r, q_r[DIV_QW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= '0;
        den_r <= den;
        neg_r <= num[31];
        q_r   <= {mag, 28'd0};
      end else if (run_r) begin
        // dividend bits leave the top as quotient bits enter the bottom
        if (!trial[34]) begin
          rem_r <= trial[32:0];
          q_r   <= {q_r[DIV_QW-2:0], 1'b1};
        end else begin
          rem_r <= shifted[32:0];
          q_r   <= {q_r[DIV_QW-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_QW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign ovf = neg_r ? ((|q_r[DIV_QW-1:32]) || (q_r[31] && (|q_r[30:0])))
                     : (|q_r[DIV_QW-1:31]);

  always_comb begin
    if (ovf)
      quo = neg_r ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else if (neg_r)
      quo = -$signed(q_r[31:0]);
    else
      quo = $signed(q_r[31:0]);
  end

  assign done = done_r;

endmodule

`default_nettype wire

FILE: rtl/abkf_cordic.sv
// Iterative vectoring CORDIC for atan2(ys, xs) in Q16.16, one rotation per cycle.
// Depends on abkf_pkg (step count, arctangent table).
`default_nettype none

module abkf_cordic
  import abkf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [15:0]   ys,
  input  wire logic signed [15:0]   xs,
  output logic                      done,
  output logic signed [ZW-1:0]      z
);

  logic signed [XYW-1:0] x_r, y_r;
  logic signed [ZW-1:0]  z_r;
  logic [CIW-1:0]        i_r;
  logic                  run_r;
  logic                  done_r;
  logic                  zero_r;
  logic                  xneg;
  logic signed [XYW-1:0] x0, y0;
  logic signed [XYW-1:0] dx, dy;
  logic signed [ZW-1:0]  ang;

  // left half plane: turn by pi first
  assign xneg = xs[15];
  assign x0   = xneg ? -XYW'(xs) : XYW'(xs);
  assign y0   = xneg ? -XYW'(ys) : XYW'(ys);
  assign dx   = y_r >>> i_r;
  assign dy   = x_r >>> i_r;
  assign ang  = atan_q16(5'(i_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        i_r    <= '0;
        zero_r <= (xs == 16'sd0) && (ys == 16'sd0);
        x_r    <= x0 <<< 14;
        y_r    <= y0 <<< 14;
        if (!xneg)
          z_r <= '0;
        else
          z_r <= ys[15] ? -PI_Q16 : PI_Q16;
      end else if (run_r) begin
        if (y_r > 0) begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + ang;
        end else begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - ang;
        end
        i_r <= i_r + 1'b1;
        if (i_r == CIW'(CORDIC_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign z    = zero_r ? '0 : z_r;

endmodule

`default_nettype wire

FILE: rtl/angle_bias_kalman_filter.sv
// Two-state (roll angle, gyro bias) Kalman filter, fixed point.
//
// Channels: in_* carries one beat per filter step: in_mode 0 is a predict
// with in_gyro_rate, in_mode 1 a correct with the in_accel_x / in_accel_y
// pair. out_* returns one beat per input beat: angle, bias-free rate, bias.
// cfg_* writes time_step (0), measure_noise (1), angle_noise (2) and
// bias_noise (3); other indexes are dropped. cfg_ready is always high.
//
// Throughput: one item at a time. in_ready is high only while the sequencer
// is idle. Work is done by a shared bit-serial multiplier, a restoring
// divider (61 steps per gain) and an iterative CORDIC.
// Per item: a predict computes four products (the off-diagonal product is
// used twice); a correct runs the CORDIC, two divisions and six products,
// and a non-positive innovation variance skips divider and multiplier.
// The result sits in an output register; the next beat is accepted while it
// waits. A stalled receiver only holds the sequencer at its final step.
// Reset (rst_n low, synchronous): state zero, covariance identity,
// registers to their defaults, no result pending.
`default_nettype none

module angle_bias_kalman_filter
  import abkf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_mode,
  input  wire logic signed [31:0] in_gyro_rate,
  input  wire logic signed [15:0] in_accel_x,
  input  wire logic signed [15:0] in_accel_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_angle,
  output logic signed [31:0]      out_angle_rate,
  output logic signed [31:0]      out_gyro_bias,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [31:0]        cfg_index,
  input  wire logic [31:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_CORD, S_DIV0, S_DIV1, S_MUL, S_MWAIT, S_OUT
  } state_t;

  // destination of a multiply-accumulate step
  typedef enum logic [2:0] {
    D_ANG, D_BIAS, D_P00, D_P01, D_P10, D_P11
  } dst_t;

  typedef struct packed {
    logic signed [MUL_OW-1:0] a;
    logic signed [MUL_OW-1:0] b;
    dst_t                     dst;
    logic                     sub;    // base minus product
    logic                     sh32;   // Q16.16 or Q4.28 x Q0.32, else Q4.28 scaling
    logic                     reuse;  // product from the previous step
    logic                     last;
  } op_t;

  state_t state_r;

  // configuration
  logic [31:0] dt_r, mn_r, an_r, bn_r;

  // filter state
  logic signed [31:0] ang_r, bias_r, rate_r;
  logic signed [31:0] p00_r, p01_r, p10_r, p11_r;

  // per-item working registers
  logic               mode_r;
  logic signed [31:0] gyro_r;
  logic signed [15:0] ax_r, ay_r;
  logic signed [31:0] unb_r, d0_r, d1_r, d3_r;
  logic signed [31:0] p00o_r, p01o_r, err_r, k0_r, k1_r;
  logic signed [33:0] e_r;
  logic [2:0]         op_r;

  // output register
  logic               out_valid_r;
  logic signed [31:0] out_ang_r, out_rate_r, out_bias_r;

  // units
  logic                     cor_start, cor_done;
  logic signed [ZW-1:0]     cor_z;
  logic                     div_start, div_done;
  logic signed [31:0]       div_num, div_q;
  logic                     mul_start, mul_done;
  logic signed [PW-1:0]     prod;
  op_t                      op;

  logic                     wb_go;
  logic signed [31:0]       base;
  logic signed [39:0]       scaled, wb_sum;
  logic signed [31:0]       wb_res;
  logic signed [31:0]       unb_nxt, d0_nxt, d1_nxt, err_nxt;
  logic signed [33:0]       e_nxt;
  logic                     out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // predict operands, taken from the state before this item
  assign unb_nxt = sat32(40'(gyro_r) - 40'(bias_r));
  assign d0_nxt  = sat32(40'($signed({1'b0, an_r[31:4]})) - 40'(p01_r) - 40'(p10_r));
  assign d1_nxt  = sat32(-40'(p11_r));
  // innovation variance R + P00
  assign e_nxt   = $signed({6'd0, mn_r[31:4]}) + 34'(p00_r);
  assign err_nxt = sat32(40'(cor_z) - 40'(ang_r));

  // step table
  always_comb begin
    op = '{a: '0, b: '0, dst: D_ANG, sub: 1'b0, sh32: 1'b0, reuse: 1'b0, last: 1'b0};
    if (!mode_r) begin
      op.b    = $signed({1'b0, dt_r});
      op.sh32 = 1'b1;
      unique case (op_r)
        3'd0: begin op.a = MUL_OW'(unb_r); op.dst = D_ANG; end
        3'd1: begin op.a = MUL_OW'(d0_r);  op.dst = D_P00; end
        3'd2: begin op.a = MUL_OW'(d1_r);  op.dst = D_P01; end
        3'd3: begin op.a = MUL_OW'(d1_r);  op.dst = D_P10; op.reuse = 1'b1; end
        3'd4: begin op.a = MUL_OW'(d3_r);  op.dst = D_P11; op.last = 1'b1; end
        default: begin op.a = '0; op.last = 1'b1; end
      endcase
    end else begin
      op.sub = 1'b1;
      unique case (op_r)
        3'd0: begin op.a = MUL_OW'(k0_r); op.b = MUL_OW'(p00o_r); op.dst = D_P00; end
        3'd1: begin op.a = MUL_OW'(k0_r); op.b = MUL_OW'(p01o_r); op.dst = D_P01; end
        3'd2: begin op.a = MUL_OW'(k1_r); op.b = MUL_OW'(p00o_r); op.dst = D_P10; end
        3'd3: begin op.a = MUL_OW'(k1_r); op.b = MUL_OW'(p01o_r); op.dst = D_P11; end
        3'd4: begin
          op.a = MUL_OW'(k0_r); op.b = MUL_OW'(err_r); op.dst = D_ANG; op.sub = 1'b0;
        end
        3'd5: begin
          op.a = MUL_OW'(k1_r); op.b = MUL_OW'(err_r); op.dst = D_BIAS; op.sub = 1'b0;
          op.last = 1'b1;
        end
        default: begin op.a = '0; op.last = 1'b1; end
      endcase
    end
  end

  // accumulate: base +/- (product >>> 32 or 28), clamped
  always_comb begin
    unique case (op.dst)
      D_ANG:   base = ang_r;
      D_BIAS:  base = bias_r;
      D_P00:   base = p00_r;
      D_P01:   base = p01_r;
      D_P10:   base = p10_r;
      D_P11:   base = p11_r;
      default: base = '0;
    endcase
  end

  assign scaled = op.sh32 ? 40'($signed(prod[PW-1:32])) : 40'($signed(prod[PW-1:28]));
  assign wb_sum = op.sub ? (40'(base) - scaled) : (40'(base) + scaled);
  assign wb_res = sat32(wb_sum);
  assign wb_go  = ((state_r == S_MWAIT) && mul_done) || ((state_r == S_MUL) && op.reuse);

  assign mul_start = (state_r == S_MUL) && !op.reuse;
  assign cor_start = (state_r == S_SETUP) && mode_r;
  assign div_start = ((state_r == S_CORD) && cor_done && !e_r[33] && (e_r != 34'sd0)) ||
                     ((state_r == S_DIV0) && div_done);
  assign div_num   = (state_r == S_CORD) ? p00_r : p10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dt_r        <= 32'd70368744;
      mn_r        <= 32'd1288490189;
      an_r        <= 32'd4294967;
      bn_r        <= 32'd12884902;
      ang_r       <= '0;
      bias_r      <= '0;
      rate_r      <= '0;
      p00_r       <= ONE_Q28;
      p01_r       <= '0;
      p10_r       <= '0;
      p11_r       <= ONE_Q28;
      op_r        <= '0;
    end else begin
      // result register: loaded by the final step, cleared by a taken beat
      if ((state_r == S_OUT) && out_free)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;

      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_TIME_STEP:     dt_r <= cfg_data;
          CFG_MEASURE_NOISE: mn_r <= cfg_data;
          CFG_ANGLE_NOISE:   an_r <= cfg_data;
          CFG_BIAS_NOISE:    bn_r <= cfg_data;
          default: ;
        endcase
      end

      if (wb_go) begin
        unique case (op.dst)
          D_ANG:   ang_r  <= wb_res;
          D_BIAS:  bias_r <= wb_res;
          D_P00:   p00_r  <= wb_res;
          D_P01:   p01_r  <= wb_res;
          D_P10:   p10_r  <= wb_res;
          D_P11:   p11_r  <= wb_res;
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_mode;
            gyro_r  <= in_gyro_rate;
            ax_r    <= in_accel_x;
            ay_r    <= in_accel_y;
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          op_r <= '0;
          if (!mode_r) begin
            unb_r   <= unb_nxt;
            rate_r  <= unb_nxt;
            d0_r    <= d0_nxt;
            d1_r    <= d1_nxt;
            d3_r    <= $signed({4'd0, bn_r[31:4]});
            state_r <= S_MUL;
          end else begin
            p00o_r  <= p00_r;
            p01o_r  <= p01_r;
            e_r     <= e_nxt;
            state_r <= S_CORD;
          end
        end
        S_CORD: begin
          if (cor_done) begin
            err_r <= err_nxt;
            // no correction when the innovation variance is not positive
            if (e_r[33] || (e_r == 34'sd0))
              state_r <= S_OUT;
            else
              state_r <= S_DIV0;
          end
        end
        S_DIV0: begin
          if (div_done) begin
            k0_r    <= div_q;
            state_r <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            k1_r    <= div_q;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (op.reuse) begin
            op_r    <= op_r + 1'b1;
            state_r <= op.last ? S_OUT : S_MUL;
          end else begin
            state_r <= S_MWAIT;
          end
        end
        S_MWAIT: begin
          if (mul_done) begin
            op_r    <= op_r + 1'b1;
            state_r <= op.last ? S_OUT : S_MUL;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_ang_r   <= ang_r;
            out_rate_r  <= rate_r;
            out_bias_r  <= bias_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_angle      = out_ang_r;
  assign out_angle_rate = out_rate_r;
  assign out_gyro_bias  = out_bias_r;

  abkf_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .ys    (ax_r),
    .xs    (ay_r),
    .done  (cor_done),
    .z     (cor_z)
  );

  abkf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (e_r[32:0]),
    .done  (div_done),
    .quo   (div_q)
  );

  abkf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (op.a),
    .b     (op.b),
    .done  (mul_done),
    .prod  (prod)
  );

endmodule

`default_nettype wire

FILE: rtl/abkf_chk.sv
// Port-level checker for angle_bias_kalman_filter, attached by bind.
// Depends on the top level's port list only.
`default_nettype none

module abkf_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_angle
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_angle))
    else $error("result changed or dropped while stalled");

  // valid only drops after a taken beat
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result dropped without handshake");

  // one item at a time: busy right after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

  // reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind angle_bias_kalman_filter abkf_chk u_abkf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_angle (out_angle)
);

`default_nettype wire

FILE: tb/angle_bias_kalman_filter_tb.sv
// Self-checking testbench for the angle/bias Kalman filter: random and directed
// predict/correct beats checked against a fixed-point model of the filter.
// Depends on rtl/abkf_pkg.sv and rtl/angle_bias_kalman_filter.sv.
`timescale 1ns / 100ps

module angle_bias_kalman_filter_tb;
  import abkf_pkg::*;

  localparam int STALL_LIMIT = 20000;  // cycles with no beat on any channel
  localparam int IDLE_PCT    = 27;

  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
    logic signed [31:0] bias;
  } filter_out_t;

  // Scoreboard: holds its own copy of the filter state and the registers,
  // predicts one result per accepted input beat and checks results in order.
  class FilterScoreboard;
    logic [31:0] dt_q32, meas_noise_q32, ang_noise_q32, bias_noise_q32;
    logic signed [31:0] angle_q16, bias_q16, rate_q16;
    logic signed [31:0] cov_q28 [4];
    filter_out_t predicted_q[$];
    int unsigned errors;
    int atan_lut [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2, 1};

    function new();
      dt_q32         = 32'd70368744;
      meas_noise_q32 = 32'd1288490189;
      ang_noise_q32  = 32'd4294967;
      bias_noise_q32 = 32'd12884902;
      angle_q16 = 0;
      bias_q16  = 0;
      rate_q16  = 0;
      cov_q28   = '{32'sh1000_0000, 0, 0, 32'sh1000_0000};
      errors    = 0;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void write_reg(logic [31:0] idx, logic [31:0] val);
      case (idx)
        CFG_TIME_STEP:     dt_q32 = val;
        CFG_MEASURE_NOISE: meas_noise_q32 = val;
        CFG_ANGLE_NOISE:   ang_noise_q32 = val;
        CFG_BIAS_NOISE:    bias_noise_q32 = val;
        default: ;
      endcase
    endfunction

    // atan2(ys, xs) in Q16.16 by vectoring; left half-plane turned by pi
    function longint tilt_atan2(longint ys, longint xs);
      longint x, y, z, dx, dy;
      x = xs;
      y = ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? 205887 : -205887;
        x = -x;
        y = -y;
      end
      x = x * 16384;
      y = y * 16384;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x = x + dx;
          y = y - dy;
          z = z + ((i < 17) ? atan_lut[i] : 0);
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - ((i < 17) ? atan_lut[i] : 0);
        end
      end
      return z;
    endfunction

    function void note_input(logic mode, logic signed [31:0] gyro,
                             logic signed [15:0] ax, logic signed [15:0] ay);
      longint dt, unb, meas, err, p00, p01, p10, e, k0, k1;
      longint d [4];
      filter_out_t res;
      dt = longint'(dt_q32);
      if (!mode) begin
        unb  = clamp32(longint'(gyro) - longint'(bias_q16));
        d[0] = clamp32(longint'(ang_noise_q32 >> 4) - longint'(cov_q28[1]) -
                       longint'(cov_q28[2]));
        d[1] = clamp32(-longint'(cov_q28[3]));
        d[2] = d[1];
        d[3] = longint'(bias_noise_q32 >> 4);
        rate_q16  = 32'(unb);
        angle_q16 = 32'(clamp32(longint'(angle_q16) + ((unb * dt) >>> 32)));
        for (int k = 0; k < 4; k++)
          cov_q28[k] = 32'(clamp32(longint'(cov_q28[k]) + ((d[k] * dt) >>> 32)));
      end else begin
        meas = tilt_atan2(longint'(ax), longint'(ay));
        err  = clamp32(meas - longint'(angle_q16));
        p00  = longint'(cov_q28[0]);
        p01  = longint'(cov_q28[1]);
        p10  = longint'(cov_q28[2]);
        e    = longint'(meas_noise_q32 >> 4) + p00;
        // non-positive innovation variance: no correction at all
        if (e > 0) begin
          k0 = clamp32((p00 * 268435456) / e);
          k1 = clamp32((p10 * 268435456) / e);
          cov_q28[0] = 32'(clamp32(p00 - ((k0 * p00) >>> 28)));
          cov_q28[1] = 32'(clamp32(p01 - ((k0 * p01) >>> 28)));
          cov_q28[2] = 32'(clamp32(p10 - ((k1 * p00) >>> 28)));
          cov_q28[3] = 32'(clamp32(longint'(cov_q28[3]) - ((k1 * p01) >>> 28)));
          angle_q16  = 32'(clamp32(longint'(angle_q16) + ((k0 * err) >>> 28)));
          bias_q16   = 32'(clamp32(longint'(bias_q16) + ((k1 * err) >>> 28)));
        end
      end
      res.angle = angle_q16;
      res.rate  = rate_q16;
      res.bias  = bias_q16;
      predicted_q.push_back(res);
    endfunction

    function void check_result(logic signed [31:0] angle, logic signed [31:0] rate,
                               logic signed [31:0] bias);
      filter_out_t exp_r;
      if (predicted_q.size() == 0) begin
        $error("unexpected result beat angle=%0d rate=%0d bias=%0d", angle, rate, bias);
        errors++;
        return;
      end
      exp_r = predicted_q.pop_front();
      if (angle !== exp_r.angle) begin
        $error("angle: expected %0d, got %0d", exp_r.angle, angle);
        errors++;
      end
      if (rate !== exp_r.rate) begin
        $error("angle_rate: expected %0d, got %0d", exp_r.rate, rate);
        errors++;
      end
      if (bias !== exp_r.bias) begin
        $error("gyro_bias: expected %0d, got %0d", exp_r.bias, bias);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic signed [31:0] in_gyro_rate = '0;
  logic signed [15:0] in_accel_x = '0;
  logic signed [15:0] in_accel_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_angle, out_angle_rate, out_gyro_bias;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  FilterScoreboard sb = new();
  bit calm = 1'b0;  // when set, neither side idles
  int unsigned quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  angle_bias_kalman_filter u_dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_mode, .in_gyro_rate, .in_accel_x, .in_accel_y,
    .out_valid, .out_ready, .out_angle, .out_angle_rate, .out_gyro_bias,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // result side: random backpressure, checked at the rising edge
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_angle, out_angle_rate, out_gyro_bias);
  end

  // watchdog: any beat on any channel resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one register write; called from a falling edge with the block idle
  task automatic write_reg(input logic [31:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one input beat; returns at the falling edge after acceptance with valid
  // still high, so the next call or the caller decides what valid does next
  task automatic send_beat(input logic mode, input logic signed [31:0] gyro,
                           input logic signed [15:0] ax, input logic signed [15:0] ay);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_gyro_rate <= gyro;
    in_accel_x   <= ax;
    in_accel_y   <= ay;
    do @(posedge clk); while (!in_ready);
    sb.note_input(mode, gyro, ax, ay);
    @(negedge clk);
  endtask

  // hold the sender until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.predicted_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_accel();
    case ($urandom_range(3))
      0:       return 16'($urandom);                                // full range
      1:       return $signed(16'($urandom_range(100))) - 16'sd50;  // near zero
      default: return $signed(16'($urandom_range(8000))) - 16'sd4000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_gyro();
    if ($urandom_range(9) == 0) return $urandom;
    return $signed(32'($urandom_range(32'h0010_0000))) - 32'sh0008_0000;
  endfunction

  task automatic random_items(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(1))
        send_beat(1'b0, rand_gyro(), 16'($urandom), 16'($urandom));
      else
        send_beat(1'b1, $urandom, rand_accel(), rand_accel());
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: field extremes, both modes, the atan2 corner cases
    send_beat(1'b0, 32'sh7FFF_FFFF, '0, '0);
    send_beat(1'b0, 32'sh8000_0000, '0, '0);
    send_beat(1'b0, 32'sh0001_0000, 16'sh7FFF, 16'sh8000);
    send_beat(1'b1, '0, 16'sd0, 16'sd0);           // zero accelerometer
    send_beat(1'b1, '0, 16'sh7FFF, 16'sh7FFF);
    send_beat(1'b1, '0, 16'sh8000, 16'sh8000);     // negative x side
    send_beat(1'b1, '0, 16'sh7FFF, 16'sh8000);
    send_beat(1'b1, '0, 16'sd0, -16'sd1);          // on the negative axis
    send_beat(1'b1, '0, -16'sd1, -16'sd1);
    send_beat(1'b1, '0, 16'sd1, 16'sd0);
    send_beat(1'b1, '0, -16'sd1, 16'sd0);
    send_beat(1'b1, 32'shFFFF_FFFF, 16'sd100, 16'sd5);
    send_beat(1'b0, -32'sd1, 16'shFFFF, 16'shFFFF);
    send_beat(1'b0, '0, '0, '0);
    random_items(300);
    drain();

    // time step and noise all zero: nothing integrates, variance can reach zero
    write_reg(CFG_TIME_STEP, 32'd0);
    write_reg(CFG_MEASURE_NOISE, 32'd0);
    write_reg(CFG_ANGLE_NOISE, 32'd0);
    write_reg(CFG_BIAS_NOISE, 32'd0);
    write_reg(32'd4, 32'hDEAD_BEEF);  // out of range index, dropped
    random_items(250);
    drain();

    // everything at its top value, no idling on either side
    calm = 1'b1;
    write_reg(CFG_TIME_STEP, 32'hFFFF_FFFF);
    write_reg(CFG_MEASURE_NOISE, 32'hFFFF_FFFF);
    write_reg(CFG_ANGLE_NOISE, 32'hFFFF_FFFF);
    write_reg(CFG_BIAS_NOISE, 32'hFFFF_FFFF);
    random_items(300);
    drain();
    calm = 1'b0;

    // random registers, then the reset values again
    for (int p = 0; p < 3; p++) begin
      write_reg(CFG_TIME_STEP, $urandom);
      write_reg(CFG_MEASURE_NOISE, $urandom);
      write_reg(CFG_ANGLE_NOISE, $urandom);
      write_reg(CFG_BIAS_NOISE, $urandom);
      random_items(200);
      drain();
    end
    write_reg(CFG_TIME_STEP, 32'd70368744);
    write_reg(CFG_MEASURE_NOISE, 32'd1288490189);
    write_reg(CFG_ANGLE_NOISE, 32'd4294967);
    write_reg(CFG_BIAS_NOISE, 32'd12884902);
    random_items(250);
    drain();

    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.predicted_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      if (sb.predicted_q.size() != 0)
        $error("%0d results never arrived", sb.predicted_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
